// ===== rtl/rpa_pkg.sv =====
// ============================================================================
// rpa_pkg
// Shared types and constants for the reference-counted page allocator:
// command and status codes, controller states and the control bundles.
// ============================================================================
package rpa_pkg;

    localparam int unsigned NUM_PAGES_DEF   = 32768;
    localparam int unsigned PAGE_SHIFT_DEF  = 12;
    localparam int unsigned COUNT_WIDTH_DEF = 8;

    localparam int unsigned START_W = 20;
    localparam int unsigned STOP_W  = 21;
    localparam logic [STOP_W-1:0] STOP_RESET = 21'd32768;

    // configuration register indexes
    localparam logic CFG_START = 1'b0;
    localparam logic CFG_STOP  = 1'b1;

    typedef enum logic [1:0] {
        CMD_ALLOC  = 2'd0,
        CMD_FREE   = 2'd1,
        CMD_INCREF = 2'd2,
        CMD_INIT   = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        STAT_OK       = 3'd0,
        STAT_OOM      = 3'd1,
        STAT_BADADDR  = 3'd2,
        STAT_NOTALLOC = 3'd3,
        STAT_SAT      = 3'd4,
        STAT_CORRUPT  = 3'd5
    } stat_t;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_LOOKUP,
        S_EXEC,
        S_INIT
    } state_t;

    // controller -> datapath
    typedef struct packed {
        logic accept;     // latch the command beat, issue first reads
        logic lookup;     // alloc: popped index is out, read its count
        logic exec;       // read-modify-write and result
        logic sweep;      // clear one count entry, advance sweep counter
        logic init_fill;  // also write the stack entry of the sweep index
        logic init_done;  // last init sweep cycle: load depth, report
    } dp_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic sweep_last;
    } dp_stat_t;

endpackage

// ===== rtl/rpa_ram.sv =====
// ============================================================================
// rpa_ram
// Generic single-write, single-read RAM with registered read data.
// ============================================================================
module rpa_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 32768
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/rpa_ctrl.sv =====
// ============================================================================
// rpa_ctrl
// Controller: sequences the clearing pass, alloc/free/incref steps and the
// init sweep, and issues commands to the datapath.
// ============================================================================
module rpa_ctrl import rpa_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    input  logic [1:0] command,
    input  dp_stat_t   dp_stat,
    output logic       busy,
    output dp_cmd_t    dp_cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        dp_cmd     = '0;
        busy       = 1'b1;
        case (state_reg)
            S_CLEAR:
            begin
                dp_cmd.sweep = 1'b1;
                if (dp_stat.sweep_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                busy = 1'b0;
                if (start)
                begin
                    dp_cmd.accept = 1'b1;
                    case (cmd_t'(command))
                        CMD_ALLOC: state_next = S_LOOKUP;
                        CMD_INIT:  state_next = S_INIT;
                        default:   state_next = S_EXEC;
                    endcase
                end
            end
            S_LOOKUP:
            begin
                dp_cmd.lookup = 1'b1;
                state_next    = S_EXEC;
            end
            S_EXEC:
            begin
                dp_cmd.exec = 1'b1;
                state_next  = S_IDLE;
            end
            S_INIT:
            begin
                dp_cmd.sweep     = 1'b1;
                dp_cmd.init_fill = 1'b1;
                if (dp_stat.sweep_last)
                begin
                    dp_cmd.init_done = 1'b1;
                    state_next       = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/rpa_datapath.sv =====
// ============================================================================
// rpa_datapath
// Datapath: configuration registers, stack pointer, count and stack RAMs,
// address checks, count update and result registers.
// ============================================================================
module rpa_datapath import rpa_pkg::*; #(
    parameter int unsigned NUM_PAGES   = NUM_PAGES_DEF,
    parameter int unsigned PAGE_SHIFT  = PAGE_SHIFT_DEF,
    parameter int unsigned COUNT_WIDTH = COUNT_WIDTH_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_valid,
    input  logic              cfg_index,
    input  logic [STOP_W-1:0] cfg_data,
    input  logic [1:0]        command,
    input  logic [31:0]       physical_address,
    input  dp_cmd_t           dp_cmd,
    output dp_stat_t          dp_stat,
    output logic              done,
    output logic [2:0]        status,
    output logic [31:0]       page_address,
    output logic [7:0]        reference_count,
    output logic              page_released,
    output logic [15:0]       free_page_count
);

    localparam int unsigned IDX_W   = $clog2(NUM_PAGES);
    localparam int unsigned DEPTH_W = $clog2(NUM_PAGES + 1);
    localparam int unsigned PAGE_W  = 32 - PAGE_SHIFT;
    localparam int unsigned WIDE_W  = STOP_W + 1;

    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX  = {COUNT_WIDTH{1'b1}};
    localparam logic [COUNT_WIDTH-1:0] COUNT_ONE  = COUNT_WIDTH'(1);
    localparam logic [DEPTH_W-1:0]     DEPTH_FULL = DEPTH_W'(NUM_PAGES);
    localparam logic [IDX_W-1:0]       SWEEP_LAST = IDX_W'(NUM_PAGES - 1);

    // configuration
    logic [START_W-1:0] start_page_reg;
    logic [STOP_W-1:0]  stop_page_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_page_reg <= '0;
            stop_page_reg  <= STOP_RESET;
        end
        else if (cfg_valid)
        begin
            if (cfg_index == CFG_START)
            begin
                start_page_reg <= cfg_data[START_W-1:0];
            end
            else
            begin
                stop_page_reg <= cfg_data;
            end
        end
    end

    // managed page count: stop - start (zero if stop <= start), capped at NUM_PAGES
    logic [WIDE_W-1:0]  start_wide;
    logic [WIDE_W-1:0]  stop_wide;
    logic [WIDE_W-1:0]  span;
    logic [DEPTH_W-1:0] managed_n;

    assign start_wide = WIDE_W'(start_page_reg);
    assign stop_wide  = WIDE_W'(stop_page_reg);
    assign span       = stop_wide - start_wide;

    always_comb
    begin
        if (stop_wide <= start_wide)
        begin
            managed_n = '0;
        end
        else if (span > WIDE_W'(NUM_PAGES))
        begin
            managed_n = DEPTH_FULL;
        end
        else
        begin
            managed_n = DEPTH_W'(span);
        end
    end

    // address to relative index
    logic [PAGE_W-1:0] in_page;
    logic [WIDE_W-1:0] in_page_wide;
    logic [WIDE_W-1:0] in_rel;
    logic              in_range;
    logic              in_aligned;
    logic [IDX_W-1:0]  in_idx;

    assign in_page      = physical_address[31:PAGE_SHIFT];
    assign in_page_wide = WIDE_W'(in_page);
    assign in_rel       = in_page_wide - start_wide;
    assign in_range     = (in_page_wide >= start_wide) && (in_rel < WIDE_W'(managed_n));
    assign in_aligned   = (physical_address[PAGE_SHIFT-1:0] == '0);
    assign in_idx       = in_range ? in_rel[IDX_W-1:0] : '0;

    // item registers
    cmd_t               cmd_reg;
    logic               bad_reg;
    logic [IDX_W-1:0]   idx_reg;
    logic [DEPTH_W-1:0] depth_reg;
    logic [DEPTH_W-1:0] depth_next;
    logic [IDX_W-1:0]   sweep_reg;

    // RAM ports
    logic                   ref_we;
    logic [IDX_W-1:0]       ref_waddr;
    logic [COUNT_WIDTH-1:0] ref_wdata;
    logic [IDX_W-1:0]       ref_raddr;
    logic [COUNT_WIDTH-1:0] ref_rdata;
    logic                   stk_we;
    logic [IDX_W-1:0]       stk_waddr;
    logic [IDX_W-1:0]       stk_wdata;
    logic [IDX_W-1:0]       stk_raddr;
    logic [IDX_W-1:0]       stk_rdata;

    logic [DEPTH_W-1:0] depth_m1;
    assign depth_m1 = depth_reg - DEPTH_W'(1);

    // execute-step results
    stat_t                  x_status;
    logic [COUNT_WIDTH-1:0] x_count;
    logic [31:0]            x_paddr;
    logic                   x_released;
    logic                   x_ref_we;
    logic [COUNT_WIDTH-1:0] x_ref_wdata;
    logic                   x_push;
    logic [DEPTH_W-1:0]     x_depth;

    logic [WIDE_W-1:0]          page_sum;
    logic [WIDE_W+PAGE_SHIFT-1:0] page_bytes;
    logic [COUNT_WIDTH-1:0]     cnt_dec;
    logic [COUNT_WIDTH-1:0]     cnt_inc;
    logic                       fill_hit;

    assign page_sum   = start_wide + WIDE_W'(idx_reg);
    assign page_bytes = {page_sum, {PAGE_SHIFT{1'b0}}};
    assign cnt_dec    = ref_rdata - COUNT_ONE;
    assign cnt_inc    = ref_rdata + COUNT_ONE;
    assign fill_hit   = DEPTH_W'(sweep_reg) < managed_n;

    always_comb
    begin
        x_status    = STAT_OK;
        x_count     = '0;
        x_paddr     = '0;
        x_released  = 1'b0;
        x_ref_we    = 1'b0;
        x_ref_wdata = '0;
        x_push      = 1'b0;
        x_depth     = depth_reg;
        case (cmd_reg)
            CMD_ALLOC:
            begin
                if (depth_reg == '0)
                begin
                    x_status = STAT_OOM;
                end
                else
                begin
                    x_depth = depth_m1;
                    if (ref_rdata != '0)
                    begin
                        x_status = STAT_CORRUPT;
                        x_count  = ref_rdata;
                    end
                    else
                    begin
                        x_ref_we    = 1'b1;
                        x_ref_wdata = COUNT_ONE;
                        x_count     = COUNT_ONE;
                        x_paddr     = page_bytes[31:0];
                    end
                end
            end
            CMD_FREE:
            begin
                if (bad_reg)
                begin
                    x_status = STAT_BADADDR;
                end
                else if (ref_rdata == '0)
                begin
                    x_status = STAT_NOTALLOC;
                end
                else
                begin
                    x_ref_we    = 1'b1;
                    x_ref_wdata = cnt_dec;
                    x_count     = cnt_dec;
                    if (cnt_dec == '0)
                    begin
                        if (depth_reg < DEPTH_FULL)
                        begin
                            x_push     = 1'b1;
                            x_released = 1'b1;
                            x_depth    = depth_reg + DEPTH_W'(1);
                        end
                        else
                        begin
                            x_status = STAT_CORRUPT;
                        end
                    end
                end
            end
            CMD_INCREF:
            begin
                if (bad_reg)
                begin
                    x_status = STAT_BADADDR;
                end
                else if (ref_rdata == '0)
                begin
                    x_status = STAT_NOTALLOC;
                end
                else if (ref_rdata == COUNT_MAX)
                begin
                    x_status = STAT_SAT;
                    x_count  = ref_rdata;
                end
                else
                begin
                    x_ref_we    = 1'b1;
                    x_ref_wdata = cnt_inc;
                    x_count     = cnt_inc;
                end
            end
            default:
            begin
                x_status = STAT_OK;
            end
        endcase
    end

    // RAM port selection
    always_comb
    begin
        ref_raddr = dp_cmd.lookup ? stk_rdata : in_idx;
        stk_raddr = (depth_reg != '0) ? depth_m1[IDX_W-1:0] : '0;

        if (dp_cmd.sweep)
        begin
            ref_we    = 1'b1;
            ref_waddr = sweep_reg;
            ref_wdata = '0;
        end
        else
        begin
            ref_we    = dp_cmd.exec && x_ref_we;
            ref_waddr = idx_reg;
            ref_wdata = x_ref_wdata;
        end

        if (dp_cmd.init_fill)
        begin
            stk_we    = fill_hit;
            stk_waddr = sweep_reg;
            stk_wdata = sweep_reg;
        end
        else
        begin
            stk_we    = dp_cmd.exec && x_push;
            stk_waddr = depth_reg[IDX_W-1:0];
            stk_wdata = idx_reg;
        end
    end

    always_comb
    begin
        depth_next = depth_reg;
        if (dp_cmd.exec)
        begin
            depth_next = x_depth;
        end
        else if (dp_cmd.init_done)
        begin
            depth_next = managed_n;
        end
    end

    assign dp_stat.sweep_last = (sweep_reg == SWEEP_LAST);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            depth_reg <= '0;
            sweep_reg <= '0;
            cmd_reg   <= CMD_ALLOC;
            done      <= 1'b0;
        end
        else
        begin
            depth_reg <= depth_next;
            done      <= dp_cmd.exec || dp_cmd.init_done;
            if (dp_cmd.sweep)
            begin
                sweep_reg <= dp_stat.sweep_last ? '0 : sweep_reg + IDX_W'(1);
            end
            if (dp_cmd.accept)
            begin
                cmd_reg <= cmd_t'(command);
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (dp_cmd.accept)
        begin
            // free also needs page alignment
            bad_reg <= !in_range ||
                       ((cmd_t'(command) == CMD_FREE) && !in_aligned);
            idx_reg <= in_idx;
        end
        else if (dp_cmd.lookup)
        begin
            idx_reg <= stk_rdata;
        end

        if (dp_cmd.exec)
        begin
            status          <= x_status;
            page_address    <= x_paddr;
            reference_count <= 8'(x_count);
            page_released   <= x_released;
            free_page_count <= 16'(x_depth);
        end
        else if (dp_cmd.init_done)
        begin
            status          <= STAT_OK;
            page_address    <= '0;
            reference_count <= '0;
            page_released   <= 1'b0;
            free_page_count <= 16'(managed_n);
        end
    end

    rpa_ram #(
        .WIDTH (COUNT_WIDTH),
        .DEPTH (NUM_PAGES)
    ) u_ref_ram (
        .clk   (clk),
        .we    (ref_we),
        .waddr (ref_waddr),
        .wdata (ref_wdata),
        .raddr (ref_raddr),
        .rdata (ref_rdata)
    );

    rpa_ram #(
        .WIDTH (IDX_W),
        .DEPTH (NUM_PAGES)
    ) u_stack_ram (
        .clk   (clk),
        .we    (stk_we),
        .waddr (stk_waddr),
        .wdata (stk_wdata),
        .raddr (stk_raddr),
        .rdata (stk_rdata)
    );

endmodule

// ===== rtl/refcounted_page_allocator.sv =====
// ============================================================================
// refcounted_page_allocator
// Physical page allocator: LIFO free stack plus a per-page reference count
// table, for copy-on-write sharing. Commands: alloc, free, incref, init.
// ============================================================================
// Steps: free and incref read the count at accept and update it in execute;
//   alloc first reads the stack, then the count (both registered RAMs).
// Throughput: a new command is taken in the cycle its result beat shows;
//   init sweeps the whole count table, one entry a cycle.
// Reset: busy stays high during the pass after reset that clears the count
//   table; configuration writes are taken at any time. The result beat is
//   shown for one cycle on done and the receiver cannot stall it.
module refcounted_page_allocator import rpa_pkg::*; #(
    parameter int unsigned NUM_PAGES   = NUM_PAGES_DEF,
    parameter int unsigned PAGE_SHIFT  = PAGE_SHIFT_DEF,
    parameter int unsigned COUNT_WIDTH = COUNT_WIDTH_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    // command channel
    input  logic              start,
    output logic              busy,
    input  logic [1:0]        command,
    input  logic [31:0]       physical_address,
    // result channel
    output logic              done,
    output logic [2:0]        status,
    output logic [31:0]       page_address,
    output logic [7:0]        reference_count,
    output logic              page_released,
    output logic [15:0]       free_page_count,
    // configuration write channel
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic              cfg_index,
    input  logic [STOP_W-1:0] cfg_data
);

    dp_cmd_t  dp_cmd;
    dp_stat_t dp_stat;

    // Registers take a write in any cycle; software writes them only while
    // the block is idle.
    assign cfg_ready = 1'b1;

    // Controller: clearing pass after reset, then the steps of each command:
    // lookup and execute for alloc, execute for free/incref, sweep for init.
    rpa_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .command (command),
        .dp_stat (dp_stat),
        .busy    (busy),
        .dp_cmd  (dp_cmd)
    );

    // Datapath: config, stack pointer, count/stack RAMs and result beat.
    rpa_datapath #(
        .NUM_PAGES   (NUM_PAGES),
        .PAGE_SHIFT  (PAGE_SHIFT),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_datapath (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_valid        (cfg_valid),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .command          (command),
        .physical_address (physical_address),
        .dp_cmd           (dp_cmd),
        .dp_stat          (dp_stat),
        .done             (done),
        .status           (status),
        .page_address     (page_address),
        .reference_count  (reference_count),
        .page_released    (page_released),
        .free_page_count  (free_page_count)
    );

endmodule
